// File: rtl/itsb_pkg.sv
package itsb_pkg;
  localparam int SERIES_DEF = 16;
  localparam int DEPTH_DEF = 256;
  localparam int TW = 48;
  localparam int VW = 32;
  localparam int CW = 9;

  typedef enum logic [1:0] {
    K_APPEND = 2'd0,
    K_QUERY  = 2'd1,
    K_EXPIRE = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_SPAN  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_LAST, S_WT_LAST, S_RD_FIRST, S_WT_FIRST, S_SRCH_RD, S_SRCH_WT,
    S_RD_A, S_WT_A, S_RD_B, S_WT_B, S_DIV, S_FIN, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    A_LAST, A_FIRST, A_MID, A_LO, A_HI
  } addr_sel_t;
endpackage

// File: rtl/itsb_if.sv
interface itsb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  series_index;
  logic [47:0] time_stamp;
  logic signed [31:0] sample_value;
  modport source (output valid, kind, series_index, time_stamp, sample_value, input ready);
  modport sink (input valid, kind, series_index, time_stamp, sample_value, output ready);
endinterface

interface itsb_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic [1:0]  status;
  logic [8:0]  dropped_count;
  logic [8:0]  fill_level;
  modport source (output valid, result_value, status, dropped_count, fill_level, input ready);
  modport sink (input valid, result_value, status, dropped_count, fill_level, output ready);
endinterface

// File: rtl/itsb_datapath.sv
module itsb_datapath #(
  parameter int SERIES = 16,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic ld,
  input  logic [1:0] kind_in,
  input  logic [3:0] sidx_in,
  input  logic [47:0] t_in,
  input  logic [31:0] v_in,
  input  itsb_pkg::addr_sel_t asel,
  input  logic rd,
  input  logic wr_app,
  input  logic cap_last,
  input  logic cap_first,
  input  logic srch_init_q,
  input  logic srch_init_e,
  input  logic srch_step,
  input  logic cap_a,
  input  logic cap_b,
  input  logic div_start,
  input  logic commit_exp,
  input  logic fin,
  output logic bad_series,
  output logic [1:0] kind,
  output logic [8:0] fill,
  output logic last_le,
  output logic span_out,
  output logic eq_first,
  output logic eq_last,
  output logic srch_done_q,
  output logic srch_done_e,
  output logic srch_exact,
  output logic div_busy,
  output logic signed [31:0] res_v,
  output logic [8:0] res_drop,
  output logic [8:0] res_fill
);
  import itsb_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = (SERIES > 1) ? $clog2(SERIES) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam int MW = 33;
  localparam int PW = MW + TW;

  logic [TW-1:0] tmem [SERIES*DEPTH];
  logic [VW-1:0] vmem [SERIES*DEPTH];
  logic [AW-1:0] head [SERIES];
  logic [NW-1:0] nfill [SERIES];

  logic [47:0] t;
  logic [31:0] v;
  logic [SW-1:0] s;
  logic [NW-1:0] n;
  logic [TW-1:0] rt, tlast, tfirst, ta, tb;
  logic [VW-1:0] rv, vlast, vfirst, va;
  logic [NW-1:0] lo, hi, mid;
  logic [NW-1:0] k;
  logic [AW-1:0] addr;
  logic [AW-1:0] waddr;
  logic [SW+AW-1:0] rd_idx, wr_idx;
  logic [PW-1:0] rem, dvd;
  logic [TW-1:0] dsor, mcand;
  logic [MW-1:0] mag, q;
  logic dneg;
  logic [6:0] cnt;
  logic dvalid;
  logic mul_on;
  logic cmp_lt;

  assign bad_series = (32'(sidx_in) >= 32'(SERIES));
  assign fill = 9'(n);
  assign mid = NW'((lo + hi) >> 1);

  always_comb begin
    case (asel)
      A_LAST:  k = n - NW'(1);
      A_FIRST: k = '0;
      A_MID:   k = mid;
      A_LO:    k = lo;
      default: k = hi;
    endcase
  end
  assign addr = AW'({1'b0, head[s]} + k[AW-1:0]);
  assign waddr = AW'({1'b0, head[s]} + n[AW-1:0]);
  assign rd_idx = {s, addr};
  assign wr_idx = {s, waddr};

  always_ff @(posedge clk) begin
    if (rd) begin
      rt <= tmem[rd_idx];
      rv <= vmem[rd_idx];
    end
    if (wr_app) begin
      tmem[wr_idx] <= t;
      vmem[wr_idx] <= v;
    end
  end

  assign cmp_lt = t < rt;
  assign last_le = t <= tlast;
  assign span_out = (t < tfirst) || (t > tlast);
  assign eq_first = t == tfirst;
  assign eq_last = t == tlast;
  assign srch_done_q = (hi - lo) <= NW'(1);
  assign srch_done_e = lo >= hi;
  assign srch_exact = (t == rt);
  assign div_busy = dvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERIES; i++) begin
        head[i] <= '0;
        nfill[i] <= '0;
      end
      dvalid <= 1'b0;
      mul_on <= 1'b0;
    end else begin
      if (ld) begin
        kind <= kind_in;
        s <= SW'(sidx_in);
        t <= t_in;
        v <= v_in;
        n <= nfill[SW'(sidx_in)];
        res_v <= '0;
        res_drop <= '0;
      end
      if (cap_last) begin
        tlast <= rt;
        vlast <= rv;
      end
      if (cap_first) begin
        tfirst <= rt;
        vfirst <= rv;
      end
      if (srch_init_q) begin
        lo <= '0;
        hi <= n - NW'(1);
      end
      if (srch_init_e) begin
        lo <= '0;
        hi <= n;
      end
      if (srch_step) begin
        if (kind == K_EXPIRE) begin
          if (rt < t) lo <= mid + NW'(1);
          else hi <= mid;
        end else if (cmp_lt) hi <= mid;
        else lo <= mid;
      end
      if (cap_a) begin
        ta <= rt;
        va <= rv;
      end
      if (cap_b) begin
        tb <= rt;
        dneg <= $signed(rv) < $signed(va);
        mag <= ($signed(rv) < $signed(va)) ?
               MW'($signed({va[31], va}) - $signed({rv[31], rv})) :
               MW'($signed({rv[31], rv}) - $signed({va[31], va}));
      end
      // Shift-add multiply of |dv| by the time offset, then a restoring divide.
      if (div_start) begin
        dvd <= '0;
        mcand <= t - ta;
        dsor <= tb - ta;
        cnt <= 7'(MW);
        mul_on <= 1'b1;
        dvalid <= 1'b1;
      end else if (mul_on) begin
        dvd <= {dvd[PW-2:0], 1'b0} + (mag[MW-1] ? PW'(mcand) : PW'(0));
        mag <= {mag[MW-2:0], 1'b0};
        if (cnt == 7'd1) begin
          mul_on <= 1'b0;
          cnt <= 7'(PW);
          rem <= '0;
          q <= '0;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end else if (dvalid) begin
        rem <= (({rem[PW-2:0], dvd[PW-1]}) >= PW'(dsor)) ?
               ({rem[PW-2:0], dvd[PW-1]} - PW'(dsor)) : {rem[PW-2:0], dvd[PW-1]};
        q <= {q[MW-2:0], ({rem[PW-2:0], dvd[PW-1]} >= PW'(dsor))};
        dvd <= {dvd[PW-2:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) dvalid <= 1'b0;
      end
      if (wr_app) begin
        nfill[s] <= n + NW'(1);
        n <= n + NW'(1);
      end
      if (commit_exp) begin
        head[s] <= AW'({1'b0, head[s]} + lo[AW-1:0]);
        nfill[s] <= n - lo;
        n <= n - lo;
        res_drop <= 9'(lo);
      end
      if (fin) begin
        if (eq_first) res_v <= vfirst;
        else if (eq_last) res_v <= vlast;
        else if (srch_exact && asel == A_MID) res_v <= rv;
        else begin
          logic signed [33:0] r;
          r = dneg ? ($signed({{2{va[31]}}, va}) - $signed({1'b0, q})) :
                     ($signed({{2{va[31]}}, va}) + $signed({1'b0, q}));
          if (r > 34'sd2147483647) res_v <= 32'h7fffffff;
          else if (r < -34'sd2147483648) res_v <= 32'h80000000;
          else res_v <= r[31:0];
        end
      end
    end
  end
  assign res_fill = 9'(n);
endmodule

// File: rtl/itsb_ctrl.sv
module itsb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic bad_series,
  input  logic [1:0] kind,
  input  logic [8:0] fill,
  input  logic last_le,
  input  logic span_out,
  input  logic eq_first,
  input  logic eq_last,
  input  logic srch_done_q,
  input  logic srch_done_e,
  input  logic srch_exact,
  input  logic div_busy,
  input  logic full,
  output logic ld,
  output itsb_pkg::addr_sel_t asel,
  output logic rd,
  output logic wr_app,
  output logic cap_last,
  output logic cap_first,
  output logic srch_init_q,
  output logic srch_init_e,
  output logic srch_step,
  output logic cap_a,
  output logic cap_b,
  output logic div_start,
  output logic commit_exp,
  output logic fin,
  output logic [1:0] status,
  output logic zero_all
);
  import itsb_pkg::*;
  state_t state, state_next;
  logic [1:0] status_next;
  logic zero_next;
  logic exact_hit, exact_hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      status <= ST_OK;
      zero_all <= 1'b0;
      exact_hit <= 1'b0;
    end else begin
      state <= state_next;
      status <= status_next;
      zero_all <= zero_next;
      exact_hit <= exact_hit_next;
    end
  end

  always_comb begin
    state_next = state;
    status_next = status;
    zero_next = zero_all;
    exact_hit_next = exact_hit;
    in_ready = 1'b0; out_valid = 1'b0; ld = 1'b0; asel = A_LAST; rd = 1'b0;
    wr_app = 1'b0; cap_last = 1'b0; cap_first = 1'b0; srch_init_q = 1'b0;
    srch_init_e = 1'b0; srch_step = 1'b0; cap_a = 1'b0; cap_b = 1'b0;
    div_start = 1'b0; commit_exp = 1'b0; fin = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ld = 1'b1;
          status_next = ST_OK;
          exact_hit_next = 1'b0;
          zero_next = bad_series;
          state_next = bad_series ? S_OUT : S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        if (kind == K_APPEND && full) begin
          status_next = ST_FULL; state_next = S_OUT;
        end else if (kind == K_NONE) state_next = S_OUT;
        else if (kind == K_EXPIRE) begin
          srch_init_e = 1'b1; state_next = S_SRCH_RD;
        end else if (fill == 9'd0) begin
          if (kind == K_APPEND) wr_app = 1'b1;
          else status_next = ST_SPAN;
          state_next = S_OUT;
        end else begin
          asel = A_LAST; rd = 1'b1; state_next = S_WT_LAST;
        end
      end
      S_WT_LAST: begin
        cap_last = 1'b1;
        state_next = (kind == K_APPEND) ? S_FIN : S_RD_FIRST;
      end
      S_RD_FIRST: begin
        asel = A_FIRST; rd = 1'b1; state_next = S_WT_FIRST;
      end
      S_WT_FIRST: begin
        cap_first = 1'b1; srch_init_q = 1'b1; state_next = S_FIN;
      end
      S_SRCH_RD: begin
        if ((kind == K_EXPIRE) ? srch_done_e : srch_done_q) begin
          if (kind == K_EXPIRE) begin
            commit_exp = 1'b1; state_next = S_OUT;
          end else begin
            asel = A_LO; rd = 1'b1; state_next = S_WT_A;
          end
        end else begin
          asel = A_MID; rd = 1'b1; state_next = S_SRCH_WT;
        end
      end
      S_SRCH_WT: begin
        if (kind == K_QUERY && srch_exact) begin
          asel = A_MID; exact_hit_next = 1'b1; state_next = S_DIV;
        end else begin
          srch_step = 1'b1; state_next = S_SRCH_RD;
        end
      end
      S_WT_A: begin
        cap_a = 1'b1; state_next = S_RD_B;
      end
      S_RD_B: begin
        asel = A_HI; rd = 1'b1; state_next = S_WT_B;
      end
      S_WT_B: begin
        state_next = S_RD_A;
      end
      S_RD_A: begin
        cap_b = 1'b1;
        state_next = S_DIV;
        exact_hit_next = 1'b0;
      end
      S_DIV: begin
        asel = A_MID;
        if (exact_hit) begin
          fin = 1'b1; state_next = S_OUT;
        end else begin
          div_start = 1'b1;
          status_next = ST_OK;
          exact_hit_next = 1'b1;
          zero_next = 1'b0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (kind == K_APPEND) begin
          if (last_le) status_next = ST_ORDER;
          else wr_app = 1'b1;
          state_next = S_OUT;
        end else if (exact_hit) begin
          if (!div_busy) begin
            asel = A_LO; fin = 1'b1; state_next = S_OUT;
          end
        end else if (span_out) begin
          status_next = ST_SPAN; state_next = S_OUT;
        end else if (eq_first || eq_last) begin
          fin = 1'b1; state_next = S_OUT;
        end else state_next = S_SRCH_RD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: rtl/interpolated_time_series_buffer.sv
// Interpolated time-series buffer.
// Request channel in_ch carries kind (append, query, expire), series index,
// time stamp (32 fraction bits) and a Q16.16 value. Response channel out_ch
// returns one result per request: interpolated value, status, dropped count
// and fill level of the series after the request.
// Requests are handled one at a time by a controller and a datapath with one
// sample memory port; in_ch.ready is high only while the controller idles.
// An append checks the last sample and then writes (an empty series is written
// at once, a full one refused); an expire runs a binary search of up to 9
// steps; a query outside the span or on an end sample answers after reading
// both ends, otherwise it runs a binary search of up to 8 steps and then finds
// the slope with a shift-add multiply followed by a restoring divide.
// A new request is taken in the cycle after the result leaves.
// The longest path: binary search reads, then the multiply and divide.
// Reset clears ring heads and fills at once; sample memory needs no clear.
// When out_ch stalls the result holds in its registers and no request is
// taken until it is delivered.
module interpolated_time_series_buffer #(
  parameter int SERIES = itsb_pkg::SERIES_DEF,
  parameter int DEPTH = itsb_pkg::DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  itsb_in_if.sink in_ch,
  itsb_out_if.source out_ch
);
  import itsb_pkg::*;
  logic ld, rd, wr_app, cap_last, cap_first, srch_init_q, srch_init_e, srch_step;
  logic cap_a, cap_b, div_start, commit_exp, fin, bad_series;
  logic last_le, span_out, eq_first, eq_last, srch_done_q, srch_done_e;
  logic srch_exact, div_busy, zero_all;
  logic [1:0] kind, status;
  logic [8:0] fill, res_drop, res_fill;
  logic signed [31:0] res_v;
  addr_sel_t asel;

  itsb_datapath #(.SERIES(SERIES), .DEPTH(DEPTH)) u_dp (
    .clk, .rst, .ld, .kind_in(in_ch.kind), .sidx_in(in_ch.series_index),
    .t_in(in_ch.time_stamp), .v_in(in_ch.sample_value), .asel, .rd, .wr_app,
    .cap_last, .cap_first, .srch_init_q, .srch_init_e, .srch_step, .cap_a, .cap_b,
    .div_start, .commit_exp, .fin, .bad_series, .kind, .fill,
    .last_le, .span_out, .eq_first, .eq_last, .srch_done_q, .srch_done_e,
    .srch_exact, .div_busy, .res_v, .res_drop, .res_fill
  );

  itsb_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .bad_series, .kind, .fill,
    .last_le, .span_out, .eq_first, .eq_last, .srch_done_q, .srch_done_e,
    .srch_exact, .div_busy, .full(32'(fill) >= 32'(DEPTH)), .ld, .asel, .rd,
    .wr_app, .cap_last, .cap_first, .srch_init_q, .srch_init_e, .srch_step,
    .cap_a, .cap_b, .div_start, .commit_exp, .fin, .status, .zero_all
  );

  // Drop every field for a request to a series that does not exist.
  assign out_ch.result_value = zero_all ? '0 : res_v;
  assign out_ch.status = zero_all ? ST_OK : status;
  assign out_ch.dropped_count = zero_all ? '0 : res_drop;
  assign out_ch.fill_level = zero_all ? '0 : res_fill;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_value))
    else $error("result dropped under stall");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> 32'(out_ch.fill_level) <= 32'(DEPTH)) else $error("fill overflow");
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import itsb_pkg::*;

  localparam int NSER = SERIES_DEF;
  localparam int NDEP = DEPTH_DEF;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 150;

  // One response as the block returns it.
  typedef struct packed {
    logic signed [31:0] value;
    status_t            st;
    logic [8:0]         dropped;
    logic [8:0]         fill;
  } lookup_res_t;

  // One row of the directed table; typed rows carry their own answer.
  typedef struct {
    kind_t              kind;
    logic [3:0]         series;
    logic [47:0]        stamp;
    logic signed [31:0] sample;
    bit                 typed;
    lookup_res_t        answer;
  } directed_row_t;

  logic clk;
  logic rst;
  longint cycle_count;

  itsb_in_if  in_ch ();
  itsb_out_if out_ch ();

  interpolated_time_series_buffer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the sample stores and ring pointers.
  logic [47:0]        shadow_time [0:NSER*NDEP-1];
  logic signed [31:0] shadow_value [0:NSER*NDEP-1];
  logic [7:0]         shadow_head [0:NSER-1];
  int                 shadow_fill [0:NSER-1];

  lookup_res_t   pending_results[$];
  directed_row_t directed_rows[$];
  bit            use_typed;
  lookup_res_t   typed_answer;

  int  requests_taken;
  int  results_checked;
  int  mismatches;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_request;
  int  hold_left;
  int  interp_hits;
  int  span_misses;
  int  full_hits;
  int  order_hits;
  int  samples_dropped;

  // Clock and the watchdog on total run length.
  initial begin
    clk = 1'b0;
    cycle_count = 0;
    forever begin
      #1 clk = 1'b1;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_results.size());
        $display("Test completed with failures");
        $finish;
      end
      #1 clk = 1'b0;
    end
  end

  function automatic int slot_of(int s, int k);
    return s * NDEP + ((shadow_head[s] + k) % NDEP);
  endfunction

  function automatic logic [47:0] time_at(int s, int k);
    return shadow_time[slot_of(s, k)];
  endfunction

  // Work out the response to one request and advance the shadow state.
  function automatic lookup_res_t lookup_step(kind_t kind, int s, logic [47:0] stamp,
                                              logic signed [31:0] sample);
    lookup_res_t r;
    int n;
    int lo;
    logic [47:0] t_lo;
    logic [47:0] t_hi;
    longint v_lo;
    longint v_hi;
    longint dv;
    longint sum;
    longint unsigned mag;
    logic [127:0] offset;
    r = '0;
    n = shadow_fill[s];
    case (kind)
      K_APPEND: begin
        if (n >= NDEP) begin
          r.st = ST_FULL;
        end else if (n > 0 && stamp <= time_at(s, n - 1)) begin
          r.st = ST_ORDER;
        end else begin
          shadow_time[slot_of(s, n)] = stamp;
          shadow_value[slot_of(s, n)] = sample;
          shadow_fill[s] = n + 1;
        end
      end
      K_QUERY: begin
        if (n == 0 || stamp < time_at(s, 0) || stamp > time_at(s, n - 1)) begin
          r.st = ST_SPAN;
        end else begin
          // find the last sample at or below the query time
          lo = 0;
          while (lo + 1 < n && time_at(s, lo + 1) <= stamp) lo++;
          if (time_at(s, lo) == stamp) begin
            r.value = shadow_value[slot_of(s, lo)];
          end else begin
            t_lo = time_at(s, lo);
            t_hi = time_at(s, lo + 1);
            v_lo = longint'(shadow_value[slot_of(s, lo)]);
            v_hi = longint'(shadow_value[slot_of(s, lo + 1)]);
            dv = v_hi - v_lo;
            mag = (dv < 0) ? longint'(-dv) : dv;
            offset = (128'(mag) * 128'(stamp - t_lo)) / 128'(t_hi - t_lo);
            sum = (dv < 0) ? v_lo - longint'(offset[63:0]) : v_lo + longint'(offset[63:0]);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            r.value = sum[31:0];
          end
        end
      end
      K_EXPIRE: begin
        lo = 0;
        while (lo < n && time_at(s, lo) < stamp) lo++;
        r.dropped = 9'(lo);
        shadow_head[s] = 8'((shadow_head[s] + lo) % NDEP);
        shadow_fill[s] = n - lo;
      end
      default: ;
    endcase
    r.fill = 9'(shadow_fill[s]);
    return r;
  endfunction

  // Monitor: take requests and responses on the rising edge.
  always @(posedge clk) begin
    lookup_res_t predicted;
    lookup_res_t got;
    if (!rst && in_ch.valid && in_ch.ready) begin
      predicted = lookup_step(kind_t'(in_ch.kind), in_ch.series_index, in_ch.time_stamp,
                              in_ch.sample_value);
      if (use_typed) predicted = typed_answer;
      pending_results.push_back(predicted);
      requests_taken++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.value = out_ch.result_value;
      got.st = status_t'(out_ch.status);
      got.dropped = out_ch.dropped_count;
      got.fill = out_ch.fill_level;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0d] response with nothing outstanding: value %0d status %0d",
                   cycle_count, got.value, got.st);
      end else begin
        predicted = pending_results.pop_front();
        results_checked++;
        if (got.st == ST_OK && got.value != 0) interp_hits++;
        if (got.st == ST_SPAN) span_misses++;
        if (got.st == ST_FULL) full_hits++;
        if (got.st == ST_ORDER) order_hits++;
        samples_dropped += got.dropped;
        if (got.value !== predicted.value || got.st !== predicted.st ||
            got.dropped !== predicted.dropped || got.fill !== predicted.fill) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0d] result %0d: exp value %0d st %0d drop %0d fill %0d, got %0d %0d %0d %0d",
                     cycle_count, results_checked, predicted.value, predicted.st,
                     predicted.dropped, predicted.fill, got.value, got.st, got.dropped, got.fill);
        end
      end
    end
  end

  // Response side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      out_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_request <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic add_row(kind_t kind, logic [3:0] s, logic [47:0] stamp,
                         logic signed [31:0] sample, bit typed,
                         logic signed [31:0] value, status_t st, int dropped, int fill);
    directed_row_t row;
    row.kind = kind;
    row.series = s;
    row.stamp = stamp;
    row.sample = sample;
    row.typed = typed;
    row.answer.value = value;
    row.answer.st = st;
    row.answer.dropped = 9'(dropped);
    row.answer.fill = 9'(fill);
    directed_rows.push_back(row);
  endtask

  // Offer one request from the falling edge and hold it until it is taken.
  task automatic send_request(kind_t kind, int s, logic [47:0] stamp,
                              logic signed [31:0] sample);
    int target;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.series_index = 4'(s);
    in_ch.time_stamp = stamp;
    in_ch.sample_value = sample;
    target = requests_taken + 1;
    @(negedge clk);
    while (requests_taken < target) @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1: return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom;
    endcase
  endfunction

  // One random request, mostly well-formed against the current shadow state.
  task automatic send_random();
    int s;
    int n;
    int pick;
    int k;
    logic [47:0] newest;
    logic [47:0] oldest;
    logic [47:0] stamp;
    logic [63:0] span;
    kind_t kind;
    s = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, NSER - 1);
    n = shadow_fill[s];
    oldest = (n > 0) ? time_at(s, 0) : 48'h0;
    newest = (n > 0) ? time_at(s, n - 1) : 48'h0;
    pick = $urandom_range(0, 99);
    stamp = {$urandom, $urandom};
    if (pick < 50) begin
      kind = K_APPEND;
      if (n > 0 && $urandom_range(0, 9) == 0)
        stamp = newest - ((newest < 3) ? newest : $urandom_range(0, 3));
      else if (n > 0)
        stamp = newest + (($urandom_range(0, 3) == 0) ? 48'($urandom) + 1
                                                       : $urandom_range(1, 1 << 20));
      else
        stamp = stamp & 48'h3FFF_FFFF_FFFF;
    end else if (pick < 85) begin
      kind = K_QUERY;
      if (n > 0) begin
        k = $urandom_range(0, 9);
        span = 64'(newest - oldest) + 1;
        if (k < 2) stamp = time_at(s, $urandom_range(0, n - 1));
        else if (k == 2) stamp = oldest - 1;
        else if (k == 3) stamp = newest + 1;
        else stamp = oldest + 48'({$urandom, $urandom} % span);
      end
    end else if (pick < 97) begin
      kind = K_EXPIRE;
      if (n > 0) begin
        k = $urandom_range(0, (n <= 4) ? n - 1 : 4);
        stamp = time_at(s, k) + $urandom_range(0, 1);
        if ($urandom_range(0, 19) == 0) stamp = oldest;
      end
    end else begin
      kind = K_NONE;
    end
    send_request(kind, s, stamp, pick_value());
  endtask

  task automatic wait_until_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Stimulus: directed table, then three phases of random requests, the first two with idling.
  initial begin
    logic [47:0] burst_time;
    int i;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.kind = K_APPEND;
    in_ch.series_index = '0;
    in_ch.time_stamp = '0;
    in_ch.sample_value = '0;
    requests_taken = 0;
    results_checked = 0;
    mismatches = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b0;
    hold_left = 0;
    use_typed = 1'b0;
    interp_hits = 0;
    span_misses = 0;
    full_hits = 0;
    order_hits = 0;
    samples_dropped = 0;
    for (i = 0; i < NSER; i++) begin
      shadow_head[i] = '0;
      shadow_fill[i] = 0;
    end
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Empty store, order rejection, extremes of time and value, span edges,
    // exact end points, rising and falling slopes, unused kind and expiry.
    add_row(K_QUERY, 1, 48'h0, 0, 1, 0, ST_SPAN, 0, 0);
    add_row(K_EXPIRE, 1, '1, 0, 1, 0, ST_OK, 0, 0);
    add_row(K_APPEND, 1, 48'h0, 32'sh80000000, 1, 0, ST_OK, 0, 1);
    add_row(K_APPEND, 1, 48'h0, 32'sh00010000, 1, 0, ST_ORDER, 0, 1);
    add_row(K_APPEND, 1, 48'h1_0000_0000, 32'sh7FFFFFFF, 1, 0, ST_OK, 0, 2);
    add_row(K_QUERY, 1, 48'h0, 0, 1, 32'sh80000000, ST_OK, 0, 2);
    add_row(K_QUERY, 1, 48'h0_8000_0000, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_QUERY, 1, 48'h1_0000_0000, 0, 1, 32'sh7FFFFFFF, ST_OK, 0, 2);
    add_row(K_QUERY, 1, 48'h1_0000_0001, 0, 1, 0, ST_SPAN, 0, 2);
    add_row(K_APPEND, 1, 48'h2_0000_0000, 0, 1, 0, ST_OK, 0, 3);
    add_row(K_QUERY, 1, 48'h1_8000_0000, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_APPEND, 1, '1, 32'sh12345678, 1, 0, ST_OK, 0, 4);
    add_row(K_QUERY, 1, 48'hFFFF_FFFF_FFFE, 0, 0, 0, ST_OK, 0, 0);
    add_row(K_QUERY, 1, 48'h2_0000_0000, 0, 1, 0, ST_OK, 0, 4);
    add_row(K_NONE, 1, '1, 32'sh7FFFFFFF, 1, 0, ST_OK, 0, 4);
    add_row(K_EXPIRE, 1, 48'h1_0000_0000, 0, 1, 0, ST_OK, 1, 3);
    add_row(K_EXPIRE, 1, 48'h0, 0, 1, 0, ST_OK, 0, 3);
    add_row(K_QUERY, 1, 48'h0, 0, 1, 0, ST_SPAN, 0, 3);
    add_row(K_EXPIRE, 1, '1, 0, 1, 0, ST_OK, 2, 1);
    add_row(K_QUERY, 1, '1, 0, 1, 32'sh12345678, ST_OK, 0, 1);
    add_row(K_APPEND, 1, '1, 0, 1, 0, ST_ORDER, 0, 1);
    add_row(K_QUERY, 15, 48'h5555_5555_5555, 0, 1, 0, ST_SPAN, 0, 0);
    add_row(K_EXPIRE, 15, 48'hAAAA_AAAA_AAAA, 0, 1, 0, ST_OK, 0, 0);
    foreach (directed_rows[r]) begin
      use_typed = directed_rows[r].typed;
      typed_answer = directed_rows[r].answer;
      send_request(directed_rows[r].kind, directed_rows[r].series, directed_rows[r].stamp,
                   directed_rows[r].sample);
    end
    wait_until_drained();
    use_typed = 1'b0;

    // Phase one: slow sender, slower receiver. Fill one series to the brim
    // and past it, then mixed traffic.
    tx_idle_pct = 34;
    rx_idle_pct = 74;
    burst_time = 48'h0000_1234_0000;
    for (i = 0; i < NDEP + 4; i++) begin
      burst_time = burst_time + $urandom_range(1, 1 << 24);
      send_request(K_APPEND, 15, burst_time, pick_value());
    end
    repeat (380) send_random();

    // Pause the sender until every outstanding result is back.
    wait_until_drained();

    // Phase two: roles swapped; a long receiver hold stalls the block.
    tx_idle_pct = 74;
    rx_idle_pct = 34;
    hold_request = 1'b1;
    repeat (650) send_random();

    // Phase three: back to back on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (650) send_random();

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d requests: %0d non-zero values, %0d outside span, %0d full, %0d out of order",
             requests_taken, interp_hits, span_misses, full_hits, order_hits);
    $display("Expiry removed %0d samples; %0d mismatches", samples_dropped, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
